// ----- design/subresource_range_subtract_macros.svh -----
// Assertion macros for the subresource range subtract checker
`ifndef SUBRESOURCE_RANGE_SUBTRACT_MACROS_SVH
`define SUBRESOURCE_RANGE_SUBTRACT_MACROS_SVH

// check while out of reset
`define SRS_ASSERT_RUN(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// check at every edge, reset included
`define SRS_ASSERT_ALL(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- design/srs_pkg.sv -----
// Types, widths and the axis split function for the subresource range subtract block
package srs_pkg;

    localparam int LAYER_BASE_W = 11;
    localparam int LAYER_CNT_W  = 12;
    localparam int MIP_BASE_W   = 4;
    localparam int MIP_CNT_W    = 5;
    localparam int ASPECT_W     = 8;
    localparam int MAX_PIECES   = 5;
    localparam int PIECE_IDX_W  = $clog2(MAX_PIECES);
    localparam int PIECE_CNT_W  = $clog2(MAX_PIECES + 1);
    localparam int AXIS_W       = 15;
    localparam int SPAN_BEFORE  = 0;
    localparam int SPAN_AFTER   = 1;
    localparam int SPAN_MID     = 2;

    typedef struct packed {
        logic [LAYER_BASE_W-1:0] src_base_layer;
        logic [LAYER_CNT_W-1:0]  src_layer_count;
        logic [MIP_BASE_W-1:0]   src_base_mip;
        logic [MIP_CNT_W-1:0]    src_mip_count;
        logic [ASPECT_W-1:0]     src_aspect;
        logic [LAYER_BASE_W-1:0] cutter_base_layer;
        logic [LAYER_CNT_W-1:0]  cutter_layer_count;
        logic [MIP_BASE_W-1:0]   cutter_base_mip;
        logic [MIP_CNT_W-1:0]    cutter_mip_count;
    } item_t;

    typedef struct packed {
        logic [LAYER_BASE_W-1:0] base_layer;
        logic [LAYER_CNT_W-1:0]  layer_count;
        logic [MIP_BASE_W-1:0]   base_mip;
        logic [MIP_CNT_W-1:0]    mip_count;
    } piece_t;

    typedef struct packed {
        piece_t [MAX_PIECES-1:0] pieces;
        logic [PIECE_CNT_W-1:0]  count;
        logic [ASPECT_W-1:0]     aspect;
    } piece_set_t;

    typedef struct packed {
        logic [2:0]              vld;
        logic [2:0][AXIS_W-1:0]  base;
        logic [2:0][AXIS_W-1:0]  cnt;
    } axis_split_t;

    function automatic axis_split_t split_axis(
        input logic signed [AXIS_W-1:0] b,
        input logic signed [AXIS_W-1:0] n,
        input logic signed [AXIS_W-1:0] cb,
        input logic signed [AXIS_W-1:0] cn
    );
        logic signed [AXIS_W-1:0] d_lo;
        logic signed [AXIS_W-1:0] d_hi;
        logic signed [AXIS_W-1:0] lo;
        logic signed [AXIS_W-1:0] hi;
        axis_split_t r;
        d_lo = cb - b;
        d_hi = cb + cn - b;
        lo = (d_lo < 0) ? '0 : ((d_lo > n) ? n : d_lo);
        hi = (d_hi < 0) ? '0 : ((d_hi > n) ? n : d_hi);
        r.vld[SPAN_BEFORE]  = (lo > 0) && (lo < n);
        r.base[SPAN_BEFORE] = b;
        r.cnt[SPAN_BEFORE]  = lo;
        r.vld[SPAN_AFTER]   = (hi > 0) && (hi < n);
        r.base[SPAN_AFTER]  = b + hi;
        r.cnt[SPAN_AFTER]   = n - hi;
        r.vld[SPAN_MID]     = hi > lo;
        r.base[SPAN_MID]    = b + lo;
        r.cnt[SPAN_MID]     = hi - lo;
        if (r.vld == 3'b000)
        begin
            r.vld[SPAN_MID]  = 1'b1;
            r.base[SPAN_MID] = b;
            r.cnt[SPAN_MID]  = n;
        end
        return r;
    endfunction

endpackage

// ----- design/srs_piece_gen.sv -----
// Combinational split of one registered item into its ordered list of pieces
module srs_piece_gen (
    input  srs_pkg::item_t      item,
    output srs_pkg::piece_set_t set
);

    localparam int NCAND = 9;

    srs_pkg::axis_split_t          lay;
    srs_pkg::axis_split_t          mip;
    logic [srs_pkg::AXIS_W-1:0]    cut_end;
    logic [2:0]                    in_cut;
    logic [NCAND-1:0]              cand_vld;
    srs_pkg::piece_t [NCAND-1:0]   cand;
    logic [srs_pkg::PIECE_CNT_W:0] pos;

    always_comb
    begin
        lay = srs_pkg::split_axis(
            signed'(srs_pkg::AXIS_W'(item.src_base_layer)),
            signed'(srs_pkg::AXIS_W'(item.src_layer_count)),
            signed'(srs_pkg::AXIS_W'(item.cutter_base_layer)),
            signed'(srs_pkg::AXIS_W'(item.cutter_layer_count)));
        mip = srs_pkg::split_axis(
            signed'(srs_pkg::AXIS_W'(item.src_base_mip)),
            signed'(srs_pkg::AXIS_W'(item.src_mip_count)),
            signed'(srs_pkg::AXIS_W'(item.cutter_base_mip)),
            signed'(srs_pkg::AXIS_W'(item.cutter_mip_count)));
        cut_end = srs_pkg::AXIS_W'(item.cutter_base_layer)
                + srs_pkg::AXIS_W'(item.cutter_layer_count);
    end

    always_comb
    begin
        for (int s = 0; s < 3; s++)
        begin
            in_cut[s] = (lay.base[s] >= srs_pkg::AXIS_W'(item.cutter_base_layer))
                     && ((lay.base[s] + lay.cnt[s]) <= cut_end);
            for (int m = 0; m < 3; m++)
            begin
                cand[s*3+m].base_layer  = lay.base[s][srs_pkg::LAYER_BASE_W-1:0];
                cand[s*3+m].layer_count = lay.cnt[s][srs_pkg::LAYER_CNT_W-1:0];
                if (in_cut[s])
                begin
                    cand_vld[s*3+m]       = lay.vld[s] && mip.vld[m];
                    cand[s*3+m].base_mip  = mip.base[m][srs_pkg::MIP_BASE_W-1:0];
                    cand[s*3+m].mip_count = mip.cnt[m][srs_pkg::MIP_CNT_W-1:0];
                end
                else
                begin
                    cand_vld[s*3+m]       = lay.vld[s] && (m == srs_pkg::SPAN_MID);
                    cand[s*3+m].base_mip  = item.src_base_mip;
                    cand[s*3+m].mip_count = item.src_mip_count;
                end
            end
        end
    end

    always_comb
    begin
        set.pieces = '0;
        pos        = '0;
        for (int c = 0; c < NCAND; c++)
        begin
            if (cand_vld[c] && (pos < (srs_pkg::PIECE_CNT_W+1)'(srs_pkg::MAX_PIECES)))
            begin
                set.pieces[pos[srs_pkg::PIECE_IDX_W-1:0]] = cand[c];
                pos = pos + 1'b1;
            end
        end
        set.count  = pos[srs_pkg::PIECE_CNT_W-1:0];
        set.aspect = item.src_aspect;
    end

endmodule

// ----- design/srs_piece_seq.sv -----
// Piece buffer that hands out one piece per beat on the result channel
module srs_piece_seq (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                set_valid,
    output logic                                set_ready,
    input  srs_pkg::piece_set_t                 set,
    output logic                                out_valid,
    input  logic                                out_ready,
    output srs_pkg::piece_t                     piece,
    output logic [srs_pkg::ASPECT_W-1:0]        aspect,
    output logic                                last
);

    logic                            buf_valid_reg, buf_valid_next;
    logic [srs_pkg::PIECE_IDX_W-1:0] idx_reg, idx_next;
    srs_pkg::piece_set_t             set_reg;
    logic                            done;
    logic                            load;

    assign last      = (srs_pkg::PIECE_CNT_W'(idx_reg) + 1'b1) == set_reg.count;
    assign done      = buf_valid_reg && out_ready && last;
    assign set_ready = !buf_valid_reg || done;
    assign load      = set_valid && set_ready;
    assign out_valid = buf_valid_reg;
    assign piece     = set_reg.pieces[idx_reg];
    assign aspect    = set_reg.aspect;

    always_comb
    begin
        buf_valid_next = buf_valid_reg;
        idx_next       = idx_reg;
        if (load)
        begin
            buf_valid_next = 1'b1;
            idx_next       = '0;
        end
        else if (done)
        begin
            buf_valid_next = 1'b0;
        end
        else if (buf_valid_reg && out_ready)
        begin
            idx_next = idx_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buf_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end
        else
        begin
            buf_valid_reg <= buf_valid_next;
            idx_reg       <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            set_reg <= set;
        end
    end

endmodule

// ----- design/subresource_range_subtract.sv -----
// First piece: an item taken at the input is held in the input register, then loaded into
// the piece buffer, which drives the first result beat; the load waits while the buffer is busy.
// Throughput: one piece per cycle while out_ready is high; an item holds the result channel
// for one beat per piece (1 to 5), set by the single piece buffer read out one entry a beat.
// A new item is taken every cycle that the input register is free or moving on.
// Reset: asynchronous, active low; clears all valid state, no item or piece pending.
module subresource_range_subtract (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [srs_pkg::LAYER_BASE_W-1:0]  src_base_layer,
    input  logic [srs_pkg::LAYER_CNT_W-1:0]   src_layer_count,
    input  logic [srs_pkg::MIP_BASE_W-1:0]    src_base_mip,
    input  logic [srs_pkg::MIP_CNT_W-1:0]     src_mip_count,
    input  logic [srs_pkg::ASPECT_W-1:0]      src_aspect,
    input  logic [srs_pkg::LAYER_BASE_W-1:0]  cutter_base_layer,
    input  logic [srs_pkg::LAYER_CNT_W-1:0]   cutter_layer_count,
    input  logic [srs_pkg::MIP_BASE_W-1:0]    cutter_base_mip,
    input  logic [srs_pkg::MIP_CNT_W-1:0]     cutter_mip_count,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [srs_pkg::LAYER_BASE_W-1:0]  piece_base_layer,
    output logic [srs_pkg::LAYER_CNT_W-1:0]   piece_layer_count,
    output logic [srs_pkg::MIP_BASE_W-1:0]    piece_base_mip,
    output logic [srs_pkg::MIP_CNT_W-1:0]     piece_mip_count,
    output logic [srs_pkg::ASPECT_W-1:0]      piece_aspect,
    output logic                              last_piece
);

    logic                in_valid_reg, in_valid_next;
    srs_pkg::item_t      item_reg;
    srs_pkg::piece_set_t set;
    srs_pkg::piece_t     piece;
    logic                set_ready;
    logic                take;

    assign in_ready = !in_valid_reg || set_ready;
    assign take     = in_valid && in_ready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (take)
        begin
            in_valid_next = 1'b1;
        end
        else if (set_ready)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg.src_base_layer     <= src_base_layer;
            item_reg.src_layer_count    <= src_layer_count;
            item_reg.src_base_mip       <= src_base_mip;
            item_reg.src_mip_count      <= src_mip_count;
            item_reg.src_aspect         <= src_aspect;
            item_reg.cutter_base_layer  <= cutter_base_layer;
            item_reg.cutter_layer_count <= cutter_layer_count;
            item_reg.cutter_base_mip    <= cutter_base_mip;
            item_reg.cutter_mip_count   <= cutter_mip_count;
        end
    end

    srs_piece_gen u_gen (
        .item (item_reg),
        .set  (set)
    );

    srs_piece_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .set_valid (in_valid_reg),
        .set_ready (set_ready),
        .set       (set),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .piece     (piece),
        .aspect    (piece_aspect),
        .last      (last_piece)
    );

    assign piece_base_layer  = piece.base_layer;
    assign piece_layer_count = piece.layer_count;
    assign piece_base_mip    = piece.base_mip;
    assign piece_mip_count   = piece.mip_count;

endmodule

// ----- design/srs_checker.sv -----
// Port-level checker for the subresource range subtract block, bound to the top level
`include "subresource_range_subtract_macros.svh"

module srs_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              in_valid,
    input logic                              in_ready,
    input logic [srs_pkg::LAYER_BASE_W-1:0]  src_base_layer,
    input logic [srs_pkg::LAYER_CNT_W-1:0]   src_layer_count,
    input logic [srs_pkg::MIP_BASE_W-1:0]    src_base_mip,
    input logic [srs_pkg::MIP_CNT_W-1:0]     src_mip_count,
    input logic [srs_pkg::ASPECT_W-1:0]      src_aspect,
    input logic [srs_pkg::LAYER_BASE_W-1:0]  cutter_base_layer,
    input logic [srs_pkg::LAYER_CNT_W-1:0]   cutter_layer_count,
    input logic [srs_pkg::MIP_BASE_W-1:0]    cutter_base_mip,
    input logic [srs_pkg::MIP_CNT_W-1:0]     cutter_mip_count,
    input logic                              out_valid,
    input logic                              out_ready,
    input logic [srs_pkg::LAYER_BASE_W-1:0]  piece_base_layer,
    input logic [srs_pkg::LAYER_CNT_W-1:0]   piece_layer_count,
    input logic [srs_pkg::MIP_BASE_W-1:0]    piece_base_mip,
    input logic [srs_pkg::MIP_CNT_W-1:0]     piece_mip_count,
    input logic [srs_pkg::ASPECT_W-1:0]      piece_aspect,
    input logic                              last_piece
);

    localparam int OUT_W = srs_pkg::LAYER_BASE_W + srs_pkg::LAYER_CNT_W
                         + srs_pkg::MIP_BASE_W + srs_pkg::MIP_CNT_W + 1;

    logic                            beat;
    logic                            fifth_beat;
    srs_pkg::item_t                  in_word;
    logic [OUT_W-1:0]                out_word;
    logic [srs_pkg::PIECE_IDX_W-1:0] seen_reg, seen_next;
    logic                            mid_reg, mid_next;
    logic [srs_pkg::ASPECT_W-1:0]    aspect_reg;

    assign beat       = out_valid && out_ready;
    assign fifth_beat = beat && (seen_reg == srs_pkg::PIECE_IDX_W'(srs_pkg::MAX_PIECES - 1));
    assign in_word    = {src_base_layer, src_layer_count, src_base_mip, src_mip_count,
                         src_aspect, cutter_base_layer, cutter_layer_count,
                         cutter_base_mip, cutter_mip_count};
    assign out_word   = {piece_base_layer, piece_layer_count, piece_base_mip,
                         piece_mip_count, last_piece};

    always_comb
    begin
        seen_next = seen_reg;
        mid_next  = mid_reg;
        if (beat)
        begin
            seen_next = last_piece ? '0 : seen_reg + 1'b1;
            mid_next  = !last_piece;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg <= '0;
            mid_reg  <= 1'b0;
        end
        else
        begin
            seen_reg <= seen_next;
            mid_reg  <= mid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (beat)
        begin
            aspect_reg <= piece_aspect;
        end
    end

    `SRS_ASSERT_RUN(a_in_hold, in_valid && !in_ready |=> in_valid && $stable(in_word), "input beat changed while stalled")
    `SRS_ASSERT_RUN(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_word), "result beat changed while stalled")
    `SRS_ASSERT_RUN(a_max_pieces, fifth_beat |-> last_piece, "more than five pieces for one item")
    `SRS_ASSERT_RUN(a_aspect_same, out_valid && mid_reg |-> piece_aspect == aspect_reg, "aspect changed within one item")
    `SRS_ASSERT_ALL(a_reset_idle, !rst_n |=> !out_valid && in_ready, "block not idle in reset")

endmodule

bind subresource_range_subtract srs_checker u_srs_checker (.*);
